[hdl/tlc_pkg.sv]
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types and constants of the two-level inclusive LRU cache unit.
// ----------------------------------------------------------------------------
package tlc_pkg;

    localparam int ADDR_W = 32;
    localparam int LAT_W  = 10;
    localparam int CYC_W  = 12;
    localparam int CNT_W  = 32;
    localparam int CIDX_W = 2;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_WALLOC  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_L1_LAT  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_L2_LAT  = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_MEM_LAT = 2'd3;

    typedef struct packed {
        logic             write_allocate;
        logic [LAT_W-1:0] l1_latency;
        logic [LAT_W-1:0] l2_latency;
        logic [LAT_W-1:0] memory_latency;
    } t_cfg;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] address;
        logic              alloc;
    } t_req;

    typedef struct packed {
        logic             l1_hit;
        logic             l2_hit;
        logic             memory_used;
        logic [CYC_W-1:0] access_cycles;
    } t_res;

    typedef struct packed {
        logic [CNT_W-1:0] l1_access;
        logic [CNT_W-1:0] l1_miss;
        logic [CNT_W-1:0] l2_access;
        logic [CNT_W-1:0] l2_miss;
        logic [CNT_W-1:0] memory;
    } t_stats;

endpackage

[hdl/tlc_front.sv]
// ----------------------------------------------------------------------------
// tlc_front
// Accepts accesses, classifies them (allocate or write-around) and queues them.
// ----------------------------------------------------------------------------
module tlc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_func,
    input  logic [31:0]   i_address,
    input  tlc_pkg::t_cfg i_cfg,
    input  logic          i_clearing,
    input  logic          i_take,
    output logic          o_busy,
    output logic          o_req_vld,
    output tlc_pkg::t_req o_req
);
    import tlc_pkg::*;

    t_req        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        n_wp, n_rp;
    logic [1:0]  n_cnt;
    logic        push, pop;

    assign o_busy    = i_clearing || (r_cnt == 2'd2);
    assign push      = i_start && !o_busy;
    assign pop       = i_take && (r_cnt != 2'd0);
    assign o_req_vld = (r_cnt != 2'd0);
    assign o_req     = r_q[r_rp];

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop  ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp].func    <= i_func;
            r_q[r_wp].address <= i_address;
            r_q[r_wp].alloc   <= !i_func || i_cfg.write_allocate;
        end
    end

endmodule

[hdl/tlc_back.sv]
// ----------------------------------------------------------------------------
// tlc_back
// Tag store sequencer: lookups, victim choice, back-invalidation and fills.
// ----------------------------------------------------------------------------
module tlc_back #(
    parameter int OFFSET_BITS = 5,
    parameter int L1_SET_BITS = 6,
    parameter int L1_WAYS     = 4,
    parameter int L2_SET_BITS = 10,
    parameter int L2_WAYS     = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tlc_pkg::t_cfg   i_cfg,
    input  logic            i_req_vld,
    input  tlc_pkg::t_req   i_req,
    output logic            o_take,
    output logic            o_clearing,
    output logic            o_valid,
    output tlc_pkg::t_res   o_res,
    output tlc_pkg::t_stats o_stats
);
    import tlc_pkg::*;

    localparam int L1_SETS = 1 << L1_SET_BITS;
    localparam int L2_SETS = 1 << L2_SET_BITS;
    localparam int SI1 = (L1_SET_BITS > 0) ? L1_SET_BITS : 1;
    localparam int SI2 = (L2_SET_BITS > 0) ? L2_SET_BITS : 1;
    localparam int T1W = ADDR_W - OFFSET_BITS - L1_SET_BITS;
    localparam int T2W = ADDR_W - OFFSET_BITS - L2_SET_BITS;
    localparam int A1W = $clog2(L1_WAYS + 1);
    localparam int A2W = $clog2(L2_WAYS + 1);
    localparam int W1I = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
    localparam int W2I = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
    localparam int E1  = 2 + A1W + T1W;
    localparam int E2  = 2 + A2W + T2W;
    localparam int NCLR = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
    localparam int CLRW = $clog2(NCLR) + 1;
    localparam logic [ADDR_W-1:0] M1 = (ADDR_W'(1) << L1_SET_BITS) - ADDR_W'(1);
    localparam logic [ADDR_W-1:0] M2 = (ADDR_W'(1) << L2_SET_BITS) - ADDR_W'(1);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_LK   = 3'd2;
    localparam logic [2:0] ST_BI   = 3'd3;
    localparam logic [2:0] ST_F1RD = 3'd4;
    localparam logic [2:0] ST_F1   = 3'd5;
    localparam logic [2:0] ST_DM   = 3'd6;

    // line entry: {valid, dirty, age, tag}
    typedef logic [L1_WAYS-1:0][E1-1:0] t_row1;
    typedef logic [L2_WAYS-1:0][E2-1:0] t_row2;

    function automatic logic [SI1-1:0] set1(logic [ADDR_W-1:0] a);
        return SI1'((a >> OFFSET_BITS) & M1);
    endfunction
    function automatic logic [SI2-1:0] set2(logic [ADDR_W-1:0] a);
        return SI2'((a >> OFFSET_BITS) & M2);
    endfunction
    function automatic logic [T1W-1:0] tag1(logic [ADDR_W-1:0] a);
        return T1W'(a >> (OFFSET_BITS + L1_SET_BITS));
    endfunction
    function automatic logic [T2W-1:0] tag2(logic [ADDR_W-1:0] a);
        return T2W'(a >> (OFFSET_BITS + L2_SET_BITS));
    endfunction
    function automatic logic [ADDR_W-1:0] addr1(logic [SI1-1:0] s, logic [T1W-1:0] t);
        return (ADDR_W'(t) << (OFFSET_BITS + L1_SET_BITS)) | (ADDR_W'(s) << OFFSET_BITS);
    endfunction
    function automatic logic [ADDR_W-1:0] addr2(logic [SI2-1:0] s, logic [T2W-1:0] t);
        return (ADDR_W'(t) << (OFFSET_BITS + L2_SET_BITS)) | (ADDR_W'(s) << OFFSET_BITS);
    endfunction

    function automatic t_row1 touch1(t_row1 row, logic [W1I-1:0] way);
        t_row1          r;
        logic [A1W-1:0] old;
        logic [A1W-1:0] a;
        r   = row;
        old = row[way][T1W +: A1W];
        r[way][T1W +: A1W] = '0;
        for (int w = 0; w < L1_WAYS; w++) begin
            a = row[w][T1W +: A1W];
            if (w != int'(way) && a < old && int'(a) + 1 < L1_WAYS)
                r[w][T1W +: A1W] = a + A1W'(1);
        end
        return r;
    endfunction
    function automatic t_row2 touch2(t_row2 row, logic [W2I-1:0] way);
        t_row2          r;
        logic [A2W-1:0] old;
        logic [A2W-1:0] a;
        r   = row;
        old = row[way][T2W +: A2W];
        r[way][T2W +: A2W] = '0;
        for (int w = 0; w < L2_WAYS; w++) begin
            a = row[w][T2W +: A2W];
            if (w != int'(way) && a < old && int'(a) + 1 < L2_WAYS)
                r[w][T2W +: A2W] = a + A2W'(1);
        end
        return r;
    endfunction

    // {hit, way}: first valid way with a matching tag
    function automatic logic [W1I:0] find1(t_row1 row, logic [T1W-1:0] t);
        logic           hit;
        logic [W1I-1:0] way;
        hit = 1'b0;
        way = '0;
        for (int w = 0; w < L1_WAYS; w++) begin
            if (!hit && row[w][E1-1] && row[w][T1W-1:0] == t) begin
                hit = 1'b1;
                way = W1I'(w);
            end
        end
        return {hit, way};
    endfunction
    function automatic logic [W2I:0] find2(t_row2 row, logic [T2W-1:0] t);
        logic           hit;
        logic [W2I-1:0] way;
        hit = 1'b0;
        way = '0;
        for (int w = 0; w < L2_WAYS; w++) begin
            if (!hit && row[w][E2-1] && row[w][T2W-1:0] == t) begin
                hit = 1'b1;
                way = W2I'(w);
            end
        end
        return {hit, way};
    endfunction

    // {was_valid, way}: first invalid way, else oldest valid, last among ties
    function automatic logic [W1I:0] victim1(t_row1 row);
        logic           inv;
        logic [W1I-1:0] sel;
        logic [W1I-1:0] best;
        logic [A1W-1:0] mx;
        inv = 1'b0; sel = '0; best = '0; mx = '0;
        for (int w = 0; w < L1_WAYS; w++) begin
            if (!inv) begin
                if (!row[w][E1-1]) begin
                    inv = 1'b1;
                    sel = W1I'(w);
                end else if (row[w][T1W +: A1W] >= mx) begin
                    mx   = row[w][T1W +: A1W];
                    best = W1I'(w);
                end
            end
        end
        return {!inv, inv ? sel : best};
    endfunction
    function automatic logic [W2I:0] victim2(t_row2 row);
        logic           inv;
        logic [W2I-1:0] sel;
        logic [W2I-1:0] best;
        logic [A2W-1:0] mx;
        inv = 1'b0; sel = '0; best = '0; mx = '0;
        for (int w = 0; w < L2_WAYS; w++) begin
            if (!inv) begin
                if (!row[w][E2-1]) begin
                    inv = 1'b1;
                    sel = W2I'(w);
                end else if (row[w][T2W +: A2W] >= mx) begin
                    mx   = row[w][T2W +: A2W];
                    best = W2I'(w);
                end
            end
        end
        return {!inv, inv ? sel : best};
    endfunction

    function automatic t_row1 rst_row1();
        t_row1 r;
        for (int w = 0; w < L1_WAYS; w++)
            r[w] = {2'b00, A1W'(L1_WAYS), T1W'(0)};
        return r;
    endfunction
    function automatic t_row2 rst_row2();
        t_row2 r;
        for (int w = 0; w < L2_WAYS; w++)
            r[w] = {2'b00, A2W'(L2_WAYS), T2W'(0)};
        return r;
    endfunction

    // tag stores, one row per set
    t_row1 r_mem1 [L1_SETS];
    t_row2 r_mem2 [L2_SETS];
    t_row1 r_rd1;
    t_row2 r_rd2;

    logic           m1_we, m1_re, m2_we, m2_re;
    logic [SI1-1:0] m1_wa, m1_ra;
    logic [SI2-1:0] m2_wa, m2_ra;
    t_row1          m1_wd;
    t_row2          m2_wd;

    logic [2:0]        r_state, n_state;
    logic [CLRW-1:0]   r_clr, n_clr;
    t_req              r_req, n_req;
    logic [ADDR_W-1:0] r_va, n_va;
    t_res              r_res, n_res;
    t_stats            r_stats, n_stats;
    logic              r_out_vld, n_out_vld;

    always_ff @(posedge i_clk) begin
        if (m1_we) r_mem1[m1_wa] <= m1_wd;
        if (m1_re) r_rd1 <= r_mem1[m1_ra];
        if (m2_we) r_mem2[m2_wa] <= m2_wd;
        if (m2_re) r_rd2 <= r_mem2[m2_ra];
    end

    logic [SI1-1:0] s1;
    logic [SI2-1:0] s2;
    logic [T1W-1:0] t1;
    logic [T2W-1:0] t2;
    assign s1 = set1(r_req.address);
    assign s2 = set2(r_req.address);
    assign t1 = tag1(r_req.address);
    assign t2 = tag2(r_req.address);

    always_comb begin
        logic [W1I:0] f1;
        logic [W2I:0] f2;
        t_row1        row1;
        t_row2        row2;
        n_state   = r_state;
        n_clr     = r_clr;
        n_req     = r_req;
        n_va      = r_va;
        n_res     = r_res;
        n_stats   = r_stats;
        n_out_vld = 1'b0;
        o_take    = 1'b0;
        m1_we = 1'b0; m1_re = 1'b0; m1_wa = s1; m1_ra = s1; m1_wd = r_rd1;
        m2_we = 1'b0; m2_re = 1'b0; m2_wa = s2; m2_ra = s2; m2_wd = r_rd2;
        f1 = '0; f2 = '0; row1 = r_rd1; row2 = r_rd2;
        case (r_state)
            ST_CLR: begin
                m1_we = (int'(r_clr) < L1_SETS);
                m1_wa = r_clr[SI1-1:0];
                m1_wd = rst_row1();
                m2_we = (int'(r_clr) < L2_SETS);
                m2_wa = r_clr[SI2-1:0];
                m2_wd = rst_row2();
                n_clr = r_clr + CLRW'(1);
                if (int'(r_clr) == NCLR - 1)
                    n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_req_vld) begin
                    o_take  = 1'b1;
                    n_req   = i_req;
                    m1_re   = 1'b1;
                    m1_ra   = set1(i_req.address);
                    m2_re   = 1'b1;
                    m2_ra   = set2(i_req.address);
                    n_state = ST_LK;
                end
            end
            ST_LK: begin
                f1 = find1(r_rd1, t1);
                f2 = find2(r_rd2, t2);
                n_res.l1_hit      = f1[W1I];
                n_res.l2_hit      = !f1[W1I] && f2[W2I];
                n_res.memory_used = !f1[W1I] && !f2[W2I];
                n_res.access_cycles = CYC_W'(i_cfg.l1_latency)
                    + (f1[W1I] ? CYC_W'(0) : CYC_W'(i_cfg.l2_latency))
                    + (n_res.memory_used ? CYC_W'(i_cfg.memory_latency) : CYC_W'(0));
                n_stats.l1_access = r_stats.l1_access + CNT_W'(1);
                if (!f1[W1I]) begin
                    n_stats.l1_miss   = r_stats.l1_miss + CNT_W'(1);
                    n_stats.l2_access = r_stats.l2_access + CNT_W'(1);
                    if (!f2[W2I]) begin
                        n_stats.l2_miss = r_stats.l2_miss + CNT_W'(1);
                        n_stats.memory  = r_stats.memory + CNT_W'(1);
                    end
                end
                if (f1[W1I]) begin
                    if (r_req.func) row1[f1[W1I-1:0]][E1-2] = 1'b1;
                    m1_we     = 1'b1;
                    m1_wd     = touch1(row1, f1[W1I-1:0]);
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end else if (f2[W2I]) begin
                    row2 = touch2(r_rd2, f2[W2I-1:0]);
                    if (!r_req.alloc) row2[f2[W2I-1:0]][E2-2] = 1'b1;
                    m2_we = 1'b1;
                    m2_wd = row2;
                    if (r_req.alloc) begin
                        n_state = ST_F1RD;
                    end else begin
                        n_out_vld = 1'b1;
                        n_state   = ST_IDLE;
                    end
                end else if (r_req.alloc) begin
                    f2 = victim2(r_rd2);
                    row2[f2[W2I-1:0]][E2-1]    = 1'b1;
                    row2[f2[W2I-1:0]][E2-2]    = 1'b0;
                    row2[f2[W2I-1:0]][T2W-1:0] = t2;
                    m2_we = 1'b1;
                    m2_wd = touch2(row2, f2[W2I-1:0]);
                    if (f2[W2I]) begin
                        // back-invalidate the first level copy of the victim
                        n_va    = addr2(s2, r_rd2[f2[W2I-1:0]][T2W-1:0]);
                        m1_re   = 1'b1;
                        m1_ra   = set1(n_va);
                        n_state = ST_BI;
                    end else begin
                        n_state = ST_F1RD;
                    end
                end else begin
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            ST_BI: begin
                f1 = find1(r_rd1, tag1(r_va));
                if (f1[W1I]) row1[f1[W1I-1:0]][E1-1] = 1'b0;
                m1_we   = 1'b1;
                m1_wa   = set1(r_va);
                m1_wd   = row1;
                n_state = ST_F1RD;
            end
            ST_F1RD: begin
                m1_re   = 1'b1;
                n_state = ST_F1;
            end
            ST_F1: begin
                f1 = victim1(r_rd1);
                row1[f1[W1I-1:0]][E1-1]    = 1'b1;
                row1[f1[W1I-1:0]][E1-2]    = 1'b0;
                row1[f1[W1I-1:0]][T1W-1:0] = t1;
                row1 = touch1(row1, f1[W1I-1:0]);
                if (r_req.func) row1[f1[W1I-1:0]][E1-2] = 1'b1;
                m1_we = 1'b1;
                m1_wd = row1;
                if (f1[W1I] && r_rd1[f1[W1I-1:0]][E1-2]) begin
                    // dirty victim: mark its second level line
                    n_va    = addr1(s1, r_rd1[f1[W1I-1:0]][T1W-1:0]);
                    m2_re   = 1'b1;
                    m2_ra   = set2(n_va);
                    n_state = ST_DM;
                end else begin
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            ST_DM: begin
                f2 = find2(r_rd2, tag2(r_va));
                if (f2[W2I]) begin
                    row2[f2[W2I-1:0]][E2-2] = 1'b1;
                    m2_we = 1'b1;
                    m2_wa = set2(r_va);
                    m2_wd = touch2(row2, f2[W2I-1:0]);
                end
                n_out_vld = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_clr     <= '0;
            r_stats   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_stats   <= n_stats;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_va  <= n_va;
        r_res <= n_res;
    end

    assign o_clearing = (r_state == ST_CLR);
    assign o_valid    = r_out_vld;
    assign o_res      = r_res;
    assign o_stats    = r_stats;

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ($past(r_state) == ST_LK || $past(r_state) == ST_F1
                       || $past(r_state) == ST_DM))
        else $error("result strobe without a finishing step");
    a_lk_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LK |-> $past(r_state) == ST_IDLE)
        else $error("lookup not started from idle");
    a_bi_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_BI |-> $past(r_state) == ST_LK)
        else $error("back-invalidate without second level fill");
    a_no_out_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLR |-> !r_out_vld && !o_take)
        else $error("activity during clearing pass");

endmodule

[hdl/two_level_inclusive_lru_cache_unit.sv]
// ----------------------------------------------------------------------------
// two_level_inclusive_lru_cache_unit
// Tag-only inclusive two-level write-back cache model with LRU and statistics.
// ----------------------------------------------------------------------------
// An access is taken when i_start is high and o_busy is low; its result shows
// on the o_ ports for exactly one cycle with o_valid, and the receiver cannot
// stall it. A two-entry queue sits between the front and the tag sequencer, so
// up to two accesses may wait while one is in flight. L1 hits, L2 hits and
// write-arounds end at the lookup; an allocating L2 hit adds an L1 row read
// and fill, a full miss also a back-invalidate for a valid L2 victim and a
// dirty mark for a dirty L1 victim. Each step of the single-port tag memories
// is a registered row read followed by a row write. After reset o_busy stays
// high for a clearing pass over max(L1 sets, L2 sets) sets (1024 at the
// defaults). Configuration writes take effect at once and belong in idle time.
module two_level_inclusive_lru_cache_unit #(
    parameter int OFFSET_BITS = 5,
    parameter int L1_SET_BITS = 6,
    parameter int L1_WAYS     = 4,
    parameter int L2_SET_BITS = 10,
    parameter int L2_WAYS     = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // access command
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_func,
    input  logic [31:0] i_address,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [9:0]  i_cfg_data,
    // result
    output logic        o_valid,
    output logic        o_l1_hit,
    output logic        o_l2_hit,
    output logic        o_memory_used,
    output logic [11:0] o_access_cycles,
    output logic [31:0] o_l1_access_total,
    output logic [31:0] o_l1_miss_total,
    output logic [31:0] o_l2_access_total,
    output logic [31:0] o_l2_miss_total,
    output logic [31:0] o_memory_total
);
    import tlc_pkg::*;

    t_cfg   r_cfg;
    t_req   q_req;
    logic   q_vld;
    logic   take;
    logic   clearing;
    t_res   res;
    t_stats stats;

    // configuration registers; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.write_allocate <= 1'b1;
            r_cfg.l1_latency     <= LAT_W'(1);
            r_cfg.l2_latency     <= LAT_W'(5);
            r_cfg.memory_latency <= LAT_W'(100);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WALLOC:  r_cfg.write_allocate <= i_cfg_data[0];
                CFG_L1_LAT:  r_cfg.l1_latency     <= i_cfg_data;
                CFG_L2_LAT:  r_cfg.l2_latency     <= i_cfg_data;
                CFG_MEM_LAT: r_cfg.memory_latency <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front: accepts and classifies, queues up to two accesses
    tlc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_func     (i_func),
        .i_address  (i_address),
        .i_cfg      (r_cfg),
        .i_clearing (clearing),
        .i_take     (take),
        .o_busy     (o_busy),
        .o_req_vld  (q_vld),
        .o_req      (q_req)
    );

    // back: tag store sequencer and counters
    tlc_back #(
        .OFFSET_BITS (OFFSET_BITS),
        .L1_SET_BITS (L1_SET_BITS),
        .L1_WAYS     (L1_WAYS),
        .L2_SET_BITS (L2_SET_BITS),
        .L2_WAYS     (L2_WAYS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_req_vld  (q_vld),
        .i_req      (q_req),
        .o_take     (take),
        .o_clearing (clearing),
        .o_valid    (o_valid),
        .o_res      (res),
        .o_stats    (stats)
    );

    assign o_l1_hit          = res.l1_hit;
    assign o_l2_hit          = res.l2_hit;
    assign o_memory_used     = res.memory_used;
    assign o_access_cycles   = res.access_cycles;
    assign o_l1_access_total = stats.l1_access;
    assign o_l1_miss_total   = stats.l1_miss;
    assign o_l2_access_total = stats.l2_access;
    assign o_l2_miss_total   = stats.l2_miss;
    assign o_memory_total    = stats.memory;

endmodule
